FILE: rtl/fslc_pkg.sv
// ----------------------------------------------------------------------------
// fslc_pkg: shared definitions for the frame slot LRU cache
// Slot count, field widths and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package fslc_pkg;

   localparam int SLOTS      = 4;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TAG_W      = 32;
   localparam int SLOT_OUT_W = 2;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the incoming request word
      logic lookup;    // compare, update recency, register the result
   } fslc_cmd_type;

endpackage

FILE: rtl/frame_slot_lru_cache.sv
// ----------------------------------------------------------------------------
// frame_slot_lru_cache: fully associative LRU tag store for frame buffer slots
// Maps frame indexes to buffer slots, evicting the least recently used slot.
// ----------------------------------------------------------------------------
// A request word (frame index, encoder-closed flag) is taken at a rising edge
// with start high and busy low. Its result (slot, hit, zero_fill) is on the
// rsp_ ports for one cycle with rsp_valid high, after the word is registered
// and then looked up into the result registers; one word per cycle is
// sustained. The receiver cannot stall, so results are never held. Throughput
// is set by the lookup: all slot tags are compared in parallel and the
// recency order is shifted in the same cycle, and the following word sees
// the updated store. busy is high only in the first cycle after reset; there
// is no clearing pass, as slot valid bits and the recency order reset at once.
// The store starts empty, so the first misses fill slots in ascending order.
// ----------------------------------------------------------------------------
module frame_slot_lru_cache (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [fslc_pkg::TAG_W-1:0]       req_frame_index,
   input  logic                             req_encoder_closed,
   output logic                             rsp_valid,
   output logic [fslc_pkg::SLOT_OUT_W-1:0]  rsp_slot,
   output logic                             rsp_hit,
   output logic                             rsp_zero_fill
);
   import fslc_pkg::*;

   fslc_cmd_type cmd;

   // sequencer: accept, lookup, strobe
   fslc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // tags, valid bits, recency order and result registers
   fslc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_frame_index    (req_frame_index),
      .req_encoder_closed (req_encoder_closed),
      .rsp_slot           (rsp_slot),
      .rsp_hit            (rsp_hit),
      .rsp_zero_fill      (rsp_zero_fill)
   );

endmodule

FILE: rtl/fslc_ctrl.sv
// ----------------------------------------------------------------------------
// fslc_ctrl: request sequencer
// Accepts request words, steps each through the lookup cycle, raises the strobe.
// ----------------------------------------------------------------------------
module fslc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   output fslc_pkg::fslc_cmd_type cmd
);
   import fslc_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic state_ff, state_in;
   logic busy_ff;
   logic rsp_valid_ff;

   assign cmd.capture = start & ~busy_ff;
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;

   // a captured word is looked up in the next cycle; back-to-back words chain
   always_comb begin
      state_in = cmd.capture ? ST_LOOKUP : ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b1;   // held for the cycle after reset only
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= cmd.lookup;
      end
   end

   // every strobe comes from an accepted word that passed through the lookup state
   a_strobe_from_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(reset) |-> $past(cmd.capture, 2))
      else $error("response strobe without accepted word");

endmodule

FILE: rtl/fslc_dp.sv
// ----------------------------------------------------------------------------
// fslc_dp: tag store and recency datapath
// Parallel tag compare, LRU victim pick, move-to-MRU and result registers.
// ----------------------------------------------------------------------------
module fslc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  fslc_pkg::fslc_cmd_type              cmd,
   input  logic [fslc_pkg::TAG_W-1:0]          req_frame_index,
   input  logic                                req_encoder_closed,
   output logic [fslc_pkg::SLOT_OUT_W-1:0]     rsp_slot,
   output logic                                rsp_hit,
   output logic                                rsp_zero_fill
);
   import fslc_pkg::*;

   localparam int PAD_W = SLOT_W + SLOT_OUT_W;

   // request word
   logic [TAG_W-1:0] tag_ff;
   logic             closed_ff;

   // store
   logic [TAG_W-1:0]  tags_ff  [SLOTS];
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOT_W-1:0] order_ff [SLOTS];
   logic [SLOT_W-1:0] order_in [SLOTS];

   // result
   logic [SLOT_OUT_W-1:0] slot_ff;
   logic                  hit_ff;
   logic                  zero_fill_ff;

   // lookup
   logic [SLOTS-1:0]  slot_match;
   logic [SLOTS-1:0]  pos_match;
   logic              hit;
   logic [SLOT_W-1:0] sel_pos;
   logic [SLOT_W-1:0] sel_slot;
   logic [PAD_W-1:0]  sel_slot_ext;

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_match[s] = valid_ff[s] && (tags_ff[s] == tag_ff);
      end
      for (int p = 0; p < SLOTS; p++) begin
         pos_match[p] = slot_match[order_ff[p]];
      end
      hit = |pos_match;
      // the match nearest the LRU end wins; a miss takes position zero
      sel_pos = '0;
      for (int p = SLOTS - 1; p >= 0; p--) begin
         if (pos_match[p]) begin
            sel_pos = SLOT_W'(p);
         end
      end
      sel_slot     = order_ff[sel_pos];
      sel_slot_ext = PAD_W'(sel_slot);
   end

   // move the selected position to the MRU end, closing the gap
   always_comb begin
      for (int i = 0; i < SLOTS - 1; i++) begin
         if (SLOT_W'(i) < sel_pos) begin
            order_in[i] = order_ff[i];
         end else begin
            order_in[i] = order_ff[i + 1];
         end
      end
      order_in[SLOTS-1] = sel_slot;
      valid_in = valid_ff;
      valid_in[sel_slot] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tag_ff    <= req_frame_index;
         closed_ff <= req_encoder_closed;
      end
      if (cmd.lookup) begin
         if (!hit) begin
            tags_ff[sel_slot] <= tag_ff;
         end
         slot_ff      <= sel_slot_ext[SLOT_OUT_W-1:0];
         hit_ff       <= hit;
         zero_fill_ff <= ~hit & closed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            order_ff[i] <= SLOT_W'(i);
         end
      end else if (cmd.lookup) begin
         valid_ff <= valid_in;
         order_ff <= order_in;
      end
   end

   assign rsp_slot      = slot_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_zero_fill = zero_fill_ff;

   // recency order stays a permutation of the slots
   logic [SLOTS-1:0] present;
   always_comb begin
      present = '0;
      for (int i = 0; i < SLOTS; i++) begin
         present[order_ff[i]] = 1'b1;
      end
   end

   a_order_perm: assert property (@(posedge clock) disable iff (reset)
      &present)
      else $error("recency order lost a slot");

   a_slot_valid_after: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.lookup) && !$past(reset) |-> valid_ff[$past(sel_slot)])
      else $error("returned slot not valid after lookup");

   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.lookup) && !$past(reset) && hit_ff |-> !zero_fill_ff)
      else $error("zero fill flagged on a hit");

   a_mru_is_result: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.lookup) && !$past(reset) |-> order_ff[SLOTS-1] == $past(sel_slot))
      else $error("returned slot is not most recently used");

endmodule

FILE: bench/frame_slot_lru_cache_tb.sv
// ----------------------------------------------------------------------------
// frame_slot_lru_cache_tb: self-checking bench for the frame slot LRU cache
// Sends directed and random frame requests and predicts every slot, hit and
// zero-fill answer with an LRU model of its own.
// ----------------------------------------------------------------------------
// The bench drives request words at the falling edge and samples at the
// rising edge. A word counts as taken at an edge with start high and busy low.
// At that edge the predictor runs, and its answer goes into a FIFO. Each
// rsp_valid strobe pops the oldest answer and checks it field by field.
// The sender idles at three rates: 16%, then 87%, then not at all. The
// receiver cannot stall, so it is not modeled.
// ----------------------------------------------------------------------------
module frame_slot_lru_cache_tb;
   import fslc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;   // far above the slowest legal run
   localparam int POOL_SIZE   = 6;        // a few more tags than slots: hits and evictions
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      logic                  hit;
      logic                  zero_fill;
   } slot_answer_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [TAG_W-1:0]      req_frame_index;
   logic                  req_encoder_closed;
   logic                  rsp_valid;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic                  rsp_hit;
   logic                  rsp_zero_fill;

   // model copy of the tag store
   logic [TAG_W-1:0]      frame_tag  [SLOTS];
   logic                  tag_live   [SLOTS];
   logic [SLOT_W-1:0]     use_order  [SLOTS];   // entry 0 = LRU, SLOTS-1 = MRU

   slot_answer_type       answers_due[$];
   logic [TAG_W-1:0]      tag_pool   [POOL_SIZE];
   int                    gap_pct;
   int                    mismatches;
   int                    cycle_count;

   frame_slot_lru_cache dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_frame_index    (req_frame_index),
      .req_encoder_closed (req_encoder_closed),
      .rsp_valid          (rsp_valid),
      .rsp_slot           (rsp_slot),
      .rsp_hit            (rsp_hit),
      .rsp_zero_fill      (rsp_zero_fill)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Empty store: nothing live, slots queued for eviction in ascending order.
   task automatic clear_store_model();
      for (int i = 0; i < SLOTS; i++) begin
         frame_tag[i] = '0;
         tag_live[i]  = 1'b0;
         use_order[i] = SLOT_W'(i);
      end
   endtask

   // LRU lookup: scan from the LRU end for a live matching tag. On a miss,
   // retag the LRU slot. Either way the slot used moves to the MRU end.
   function automatic slot_answer_type lru_lookup(input logic [TAG_W-1:0] tag,
                                                  input logic closed);
      slot_answer_type   ans;
      int                hit_pos;
      logic [SLOT_W-1:0] s;
      hit_pos = -1;
      for (int pos = 0; pos < SLOTS; pos++) begin
         if (hit_pos < 0 && tag_live[use_order[pos]] && frame_tag[use_order[pos]] == tag)
            hit_pos = pos;
      end
      ans.hit = (hit_pos >= 0);
      if (hit_pos < 0) hit_pos = 0;
      s = use_order[hit_pos];
      for (int i = hit_pos; i + 1 < SLOTS; i++)
         use_order[i] = use_order[i + 1];
      use_order[SLOTS - 1] = s;
      if (!ans.hit) begin
         frame_tag[s] = tag;
         tag_live[s]  = 1'b1;
      end
      ans.slot      = SLOT_OUT_W'(s);
      ans.zero_fill = ans.hit ? 1'b0 : closed;
      return ans;
   endfunction

   // Tags with every bit pattern class: random, walking one, walking zero.
   function automatic logic [TAG_W-1:0] pick_tag();
      logic [TAG_W-1:0] t;
      case ($urandom_range(3))
         0:       t = TAG_W'(1) << $urandom_range(TAG_W - 1);
         1:       t = ~(TAG_W'(1) << $urandom_range(TAG_W - 1));
         default: t = TAG_W'($urandom);
      endcase
      return t;
   endfunction

   // Send one request word. Entered just after a rising edge (or at reset
   // release). Returns at the edge that took the word, with start still high.
   task automatic send_word(input logic [TAG_W-1:0] tag, input logic closed);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start              <= 1'b1;
      req_frame_index    <= tag;
      req_encoder_closed <= closed;
      do @(posedge clock); while (busy);
   endtask

   // Empty store: misses fill slots 0..3 in order. Tag zero must not hit
   // against slots that were never written.
   task automatic test_fill_from_empty();
      gap_pct = 16;
      send_word('0, 1'b0);
      send_word('1, 1'b1);
      send_word(TAG_W'(1), 1'b0);
      send_word(TAG_W'(32'h8000_0000), 1'b1);
   endtask

   // Hits, including a hit with the encoder closed (no zero fill) and a
   // second hit on a tag that was hit before.
   task automatic test_hit_paths();
      send_word('0, 1'b1);
      send_word('1, 1'b0);
      send_word('0, 1'b0);
      send_word(TAG_W'(1), 1'b1);
   endtask

   // Evictions: a plain miss, a closed miss (still evicts), a request for a
   // tag evicted earlier in the test, and the same new tag twice back to back.
   task automatic test_eviction();
      send_word(TAG_W'(32'hAAAA_AAAA), 1'b0);
      send_word(TAG_W'(32'h5555_5555), 1'b1);
      send_word(TAG_W'(32'h8000_0000), 1'b0);
      send_word(TAG_W'(32'h1234_5678), 1'b1);
      send_word(TAG_W'(32'h1234_5678), 1'b0);
   endtask

   // Mostly tags from a small pool that drifts over time, so the
   // store sees steady hit/miss mixes; the rest are fresh tags.
   task automatic test_random_traffic(input int words, input int idle_pct);
      logic [TAG_W-1:0] tag;
      gap_pct = idle_pct;
      for (int n = 0; n < words; n++) begin
         if ($urandom_range(19) == 0)
            tag_pool[$urandom_range(POOL_SIZE - 1)] = pick_tag();
         tag = ($urandom_range(99) < 80) ? tag_pool[$urandom_range(POOL_SIZE - 1)]
                                         : pick_tag();
         send_word(tag, ($urandom_range(9) < 3));
      end
   endtask

   // Predict on every accepted word, check on every strobe.
   always @(posedge clock) begin
      slot_answer_type want;
      slot_answer_type got;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{slot: rsp_slot, hit: rsp_hit, zero_fill: rsp_zero_fill};
            if (answers_due.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("cycle %0d: result with none due: slot %0d hit %0b zf %0b",
                           cycle_count, got.slot, got.hit, got.zero_fill);
               mismatches++;
            end else begin
               want = answers_due.pop_front();
               if (got.slot !== want.slot || got.hit !== want.hit ||
                   got.zero_fill !== want.zero_fill) begin
                  if (mismatches < MAX_REPORTS)
                     $display("cycle %0d: slot %0d/%0d hit %0b/%0b zf %0b/%0b (exp/act)",
                              cycle_count, want.slot, got.slot, want.hit, got.hit,
                              want.zero_fill, got.zero_fill);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            answers_due = {answers_due, lru_lookup(req_frame_index, req_encoder_closed)};
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_frame_index    = '0;
      req_encoder_closed = 1'b0;
      gap_pct            = 0;
      mismatches         = 0;
      cycle_count        = 0;
      clear_store_model();
      for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = pick_tag();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_from_empty();
      test_hit_paths();
      test_eviction();
      test_random_traffic(150, 16);
      test_random_traffic(150, 87);
      test_random_traffic(150, 0);

      @(negedge clock);
      start <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);   // catch any stray strobe
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
